@@ src/ijm_pkg.sv @@
// ijm_pkg: types, codes and constants shared by the i2c master job engine
// used by the front decoder, the item queue, the bus engine and the top level
// no dependencies
package ijm_pkg;

   localparam int BUFFER_DEPTH_DEF = 16;
   localparam int ADDR_W           = 7;
   localparam int LEN_W            = 5;
   localparam int POS_W            = 4;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = 2;
   localparam int QCNT_W           = 3;
   localparam int BITS_PER_BYTE    = 8;

   typedef enum logic [1:0] {
      KIND_TICK       = 2'd0,
      KIND_LOAD       = 2'd1,
      KIND_WRITE_JOB  = 2'd2,
      KIND_READ_JOB   = 2'd3
   } item_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ADDR_NACK = 2'd1,
      STATUS_DATA_NACK = 2'd2
   } job_status_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_SEND_LOW  = 4'd1,
      PH_SEND_HIGH = 4'd2,
      PH_ACK_LOW   = 4'd3,
      PH_ACK_HIGH  = 4'd4,
      PH_RECV_LOW  = 4'd5,
      PH_RECV_HIGH = 4'd6,
      PH_MACK_LOW  = 4'd7,
      PH_MACK_HIGH = 4'd8,
      PH_STOP_A    = 4'd9,
      PH_STOP_B    = 4'd10,
      PH_STOP_C    = 4'd11
   } phase_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       data_byte;
      logic [POS_W-1:0] position;
      logic [LEN_W-1:0] job_length;
      logic             sda_sample;
   } req_word_type;

   typedef struct packed {
      logic             scl_level;
      logic             sda_pull_low;
      logic             read_valid;
      logic [7:0]       read_data;
      logic [POS_W-1:0] read_slot;
      logic             request_accepted;
      logic             busy_res;
      logic             job_done;
      logic [1:0]       job_status;
   } rsp_word_type;

   // classified item as held in the queue
   typedef struct packed {
      item_kind_type    kind;
      logic [7:0]       data_byte;
      logic [POS_W-1:0] position;
      logic [LEN_W-1:0] length;
      logic             load_ok;
      logic             sda_sample;
   } item_type;

endpackage

@@ src/i2c_master_job_engine.sv @@
// i2c master job engine: one word in and one word out per cycle when not stalled
// a taken word is written into the queue, popped by the bus engine, and its result is registered in the result register
// throughput: one word per cycle while the result channel is not stalled, as the bus engine updates per item
// a four-word queue sits between the decoder and the engine; the result register frees whenever it is not stalled
// reset clears queue, job state and pins (scl high, sda released); the write buffer is not cleared
// depends on ijm_pkg, ijm_front, ijm_queue, ijm_engine
module i2c_master_job_engine import ijm_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_word_type      req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_wdata
);

   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_not_empty;
   item_type push_item;
   item_type head_item;

   ijm_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   ijm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   ijm_engine #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .q_not_empty (q_not_empty),
      .q_item      (head_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

endmodule

@@ src/ijm_front.sv @@
// ijm_front: decodes an incoming word into a classified item for the queue
// clamps job lengths to the buffer depth and checks load slots
// depends on ijm_pkg
module ijm_front import ijm_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  logic         q_full,
   output logic         q_push,
   output item_type     q_item
);

   always_comb begin
      q_item.kind       = item_kind_type'(req_word.kind);
      q_item.data_byte  = req_word.data_byte;
      q_item.position   = req_word.position;
      q_item.sda_sample = req_word.sda_sample;
      q_item.load_ok    = (int'(req_word.position) < BUFFER_DEPTH);
      if (int'(req_word.job_length) > BUFFER_DEPTH) begin
         q_item.length = LEN_W'(BUFFER_DEPTH);
      end else begin
         q_item.length = req_word.job_length;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

@@ src/ijm_queue.sv @@
// ijm_queue: short fifo of classified items between front and bus engine
// depends on ijm_pkg
module ijm_queue import ijm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head_item
);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/ijm_engine.sv @@
// ijm_engine: bus engine, job bookkeeping, write buffer memory and result register
// carries out one queued item per cycle when the result register is free
// depends on ijm_pkg
module ijm_engine import ijm_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ADDR_W-1:0] csr_wdata,
   input  logic              q_not_empty,
   input  item_type          q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_word_type      rsp_word
);

   localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   phase_type         phase_ff, phase_in;
   logic [3:0]        bit_cnt_ff, bit_cnt_in;
   logic [7:0]        shift_ff, shift_in, shift_eff;
   logic              fetch_ff, fetch_in;
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [LEN_W-1:0]  bl_now, bl_dec;
   logic              wr_pend_ff, wr_pend_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [LEN_W-1:0]  wr_count_ff, wr_count_in;
   logic [LEN_W-1:0]  rd_count_ff, rd_count_in;
   logic              is_read_ff, is_read_in;
   logic              addr_ph_ff, addr_ph_in;
   job_status_type    status_ff, status_in;
   logic              scl_ff, scl_in;
   logic              sdal_ff, sdal_in;
   logic [ADDR_W-1:0] target_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic [7:0]        buf_mem [BUFFER_DEPTH];
   logic [7:0]        mem_q_ff;
   logic              mem_we, mem_re;
   logic [IDX_W-1:0]  mem_wa, mem_ra;

   assign csr_ready = 1'b1;
   assign q_pop     = q_not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a data byte read from the buffer lands in the cycle after the ack tick
   assign shift_eff = fetch_ff ? mem_q_ff : shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      bit_cnt_in    = bit_cnt_ff;
      shift_in      = shift_ff;
      fetch_in      = fetch_ff;
      bytes_left_in = bytes_left_ff;
      wr_pend_in    = wr_pend_ff;
      rd_pend_in    = rd_pend_ff;
      wr_count_in   = wr_count_ff;
      rd_count_in   = rd_count_ff;
      is_read_in    = is_read_ff;
      addr_ph_in    = addr_ph_ff;
      status_in     = status_ff;
      scl_in        = scl_ff;
      sdal_in       = sdal_ff;
      mem_we        = 1'b0;
      mem_wa        = IDX_W'(q_item.position);
      mem_re        = 1'b0;
      bl_now        = addr_ph_ff ? (is_read_ff ? rd_count_ff : wr_count_ff) : bytes_left_ff;
      bl_dec        = bl_now - 1'b1;
      mem_ra        = IDX_W'(bl_dec);
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (q_pop) begin
         shift_in     = shift_eff;
         fetch_in     = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_word_in  = '0;
         unique case (q_item.kind)
            KIND_TICK: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     scl_in  = 1'b1;
                     sdal_in = 1'b0;
                     if (wr_pend_ff || rd_pend_ff) begin
                        is_read_in = !wr_pend_ff;
                        addr_ph_in = 1'b1;
                        status_in  = STATUS_OK;
                        sdal_in    = 1'b1;
                        shift_in   = {target_ff, !wr_pend_ff};
                        bit_cnt_in = '0;
                        phase_in   = PH_SEND_LOW;
                     end
                  end
                  PH_SEND_LOW: begin
                     scl_in   = 1'b0;
                     sdal_in  = !shift_eff[7];
                     phase_in = PH_SEND_HIGH;
                  end
                  PH_SEND_HIGH: begin
                     scl_in     = 1'b1;
                     shift_in   = {shift_eff[6:0], 1'b0};
                     bit_cnt_in = bit_cnt_ff + 1'b1;
                     phase_in   = (bit_cnt_ff == 4'(BITS_PER_BYTE - 1)) ? PH_ACK_LOW
                                                                        : PH_SEND_LOW;
                  end
                  PH_ACK_LOW: begin
                     scl_in   = 1'b0;
                     sdal_in  = 1'b0;
                     phase_in = PH_ACK_HIGH;
                  end
                  PH_ACK_HIGH: begin
                     scl_in  = 1'b1;
                     sdal_in = 1'b0;
                     if (q_item.sda_sample) begin
                        status_in = addr_ph_ff ? STATUS_ADDR_NACK : STATUS_DATA_NACK;
                        phase_in  = PH_STOP_A;
                     end else begin
                        addr_ph_in    = 1'b0;
                        bytes_left_in = bl_now;
                        if (bl_now == '0) begin
                           status_in = STATUS_OK;
                           phase_in  = PH_STOP_A;
                        end else begin
                           bytes_left_in = bl_dec;
                           bit_cnt_in    = '0;
                           if (is_read_ff) begin
                              shift_in = '0;
                              phase_in = PH_RECV_LOW;
                           end else begin
                              mem_re   = 1'b1;
                              fetch_in = 1'b1;
                              phase_in = PH_SEND_LOW;
                           end
                        end
                     end
                  end
                  PH_RECV_LOW: begin
                     scl_in   = 1'b0;
                     sdal_in  = 1'b0;
                     phase_in = PH_RECV_HIGH;
                  end
                  PH_RECV_HIGH: begin
                     scl_in     = 1'b1;
                     shift_in   = {shift_eff[6:0], q_item.sda_sample};
                     bit_cnt_in = bit_cnt_ff + 1'b1;
                     if (bit_cnt_ff == 4'(BITS_PER_BYTE - 1)) begin
                        rsp_word_in.read_valid = 1'b1;
                        rsp_word_in.read_data  = {shift_eff[6:0], q_item.sda_sample};
                        rsp_word_in.read_slot  = bytes_left_ff[POS_W-1:0];
                        phase_in               = PH_MACK_LOW;
                     end else begin
                        phase_in = PH_RECV_LOW;
                     end
                  end
                  PH_MACK_LOW: begin
                     scl_in   = 1'b0;
                     // nack after the last byte
                     sdal_in  = (bytes_left_ff != '0);
                     phase_in = PH_MACK_HIGH;
                  end
                  PH_MACK_HIGH: begin
                     scl_in = 1'b1;
                     if (bytes_left_ff == '0) begin
                        status_in = STATUS_OK;
                        phase_in  = PH_STOP_A;
                     end else begin
                        bytes_left_in = bytes_left_ff - 1'b1;
                        shift_in      = '0;
                        bit_cnt_in    = '0;
                        phase_in      = PH_RECV_LOW;
                     end
                  end
                  PH_STOP_A: begin
                     scl_in   = 1'b0;
                     sdal_in  = 1'b1;
                     phase_in = PH_STOP_B;
                  end
                  PH_STOP_B: begin
                     scl_in   = 1'b1;
                     sdal_in  = 1'b1;
                     phase_in = PH_STOP_C;
                  end
                  PH_STOP_C: begin
                     scl_in                 = 1'b1;
                     sdal_in                = 1'b0;
                     rsp_word_in.job_done   = 1'b1;
                     rsp_word_in.job_status = status_ff;
                     if (is_read_ff) begin
                        rd_pend_in = 1'b0;
                     end else begin
                        wr_pend_in = 1'b0;
                     end
                     phase_in = PH_IDLE;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            KIND_LOAD: begin
               if (q_item.load_ok) begin
                  mem_we                       = 1'b1;
                  rsp_word_in.request_accepted = 1'b1;
               end
            end
            KIND_WRITE_JOB: begin
               if (!wr_pend_ff) begin
                  wr_pend_in                   = 1'b1;
                  wr_count_in                  = q_item.length;
                  rsp_word_in.request_accepted = 1'b1;
               end
            end
            KIND_READ_JOB: begin
               if (!rd_pend_ff) begin
                  rd_pend_in                   = 1'b1;
                  rd_count_in                  = q_item.length;
                  rsp_word_in.request_accepted = 1'b1;
               end
            end
            default: begin
               rsp_word_in.request_accepted = 1'b0;
            end
         endcase
         rsp_word_in.scl_level    = scl_in;
         rsp_word_in.sda_pull_low = sdal_in;
         rsp_word_in.busy_res     = wr_pend_in || rd_pend_in || (phase_in != PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_cnt_ff    <= '0;
         shift_ff      <= '0;
         fetch_ff      <= 1'b0;
         bytes_left_ff <= '0;
         wr_pend_ff    <= 1'b0;
         rd_pend_ff    <= 1'b0;
         wr_count_ff   <= '0;
         rd_count_ff   <= '0;
         is_read_ff    <= 1'b0;
         addr_ph_ff    <= 1'b0;
         status_ff     <= STATUS_OK;
         scl_ff        <= 1'b1;
         sdal_ff       <= 1'b0;
         target_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         bit_cnt_ff    <= bit_cnt_in;
         shift_ff      <= shift_in;
         fetch_ff      <= fetch_in;
         bytes_left_ff <= bytes_left_in;
         wr_pend_ff    <= wr_pend_in;
         rd_pend_ff    <= rd_pend_in;
         wr_count_ff   <= wr_count_in;
         rd_count_ff   <= rd_count_in;
         is_read_ff    <= is_read_in;
         addr_ph_ff    <= addr_ph_in;
         status_ff     <= status_in;
         scl_ff        <= scl_in;
         sdal_ff       <= sdal_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            target_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   // write buffer, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[mem_wa] <= q_item.data_byte;
      end
      if (mem_re) begin
         mem_q_ff <= buf_mem[mem_ra];
      end
   end

endmodule

@@ src/ijm_checker.sv @@
// ijm_checker: port-level checks on the i2c master job engine result channel
// depends on ijm_pkg; bound to i2c_master_job_engine
module ijm_checker import ijm_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word
);

   // stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // a received byte is reported on a high clock half with sda released
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.read_valid |->
         rsp_word.scl_level && !rsp_word.sda_pull_low && rsp_word.busy_res)
      else $error("read byte reported outside a receive high half");

   // job end is the stop condition's last half
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.job_done |->
         rsp_word.scl_level && !rsp_word.sda_pull_low && !rsp_word.request_accepted)
      else $error("job done without stop levels");

   // status only travels with job done
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.job_status != STATUS_OK) |-> rsp_word.job_done)
      else $error("status without job done");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind i2c_master_job_engine ijm_checker u_ijm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

@@ verif/tb_i2c_master_job_engine.sv @@
// testbench for the i2c master job engine: drives request words, checks every result word
// against a cycle-free model of the bus engine kept in a small scoreboard class
// depends on ijm_pkg and i2c_master_job_engine
module tb_i2c_master_job_engine;
   import ijm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TARGET    = 1850;
   localparam int PHASES         = 4;

   class job_scoreboard;
      rsp_word_type      expected_words[$];
      int                errors;
      int                word_no;
      logic [ADDR_W-1:0] target;
      logic [7:0]        wbuf [BUFFER_DEPTH_DEF];
      logic              w_pend, r_pend, is_read, in_addr, scl, sda_low;
      logic [LEN_W-1:0]  w_cnt, r_cnt, left;
      phase_type         phase;
      logic [3:0]        bitc;
      logic [7:0]        shreg;
      job_status_type    pstat;

      function new();
         errors  = 0;
         word_no = 0;
         target  = '0;
         foreach (wbuf[i]) wbuf[i] = '0;
         w_pend  = 0;
         r_pend  = 0;
         is_read = 0;
         in_addr = 0;
         scl     = 1;
         sda_low = 0;
         w_cnt   = '0;
         r_cnt   = '0;
         left    = '0;
         phase   = PH_IDLE;
         bitc    = '0;
         shreg   = '0;
         pstat   = STATUS_OK;
      endfunction

      function void set_target(logic [ADDR_W-1:0] a);
         target = a;
      endfunction

      function bit busy();
         return w_pend || r_pend || phase != PH_IDLE;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] n);
         return (n > BUFFER_DEPTH_DEF) ? LEN_W'(BUFFER_DEPTH_DEF) : n;
      endfunction

      function void start_byte(logic [7:0] b);
         shreg = b;
         bitc  = '0;
         phase = PH_SEND_LOW;
      endfunction

      function void start_recv();
         shreg = '0;
         bitc  = '0;
         phase = PH_RECV_LOW;
      endfunction

      // one bit-half of the bus
      function void bus_tick(logic sda, inout rsp_word_type r);
         case (phase)
            PH_IDLE: begin
               scl     = 1;
               sda_low = 0;
               if (w_pend || r_pend) begin
                  is_read = !w_pend;
                  in_addr = 1;
                  pstat   = STATUS_OK;
                  sda_low = 1;
                  start_byte({target, is_read});
               end
            end
            PH_SEND_LOW: begin
               scl     = 0;
               sda_low = !shreg[7];
               phase   = PH_SEND_HIGH;
            end
            PH_SEND_HIGH: begin
               scl   = 1;
               shreg = {shreg[6:0], 1'b0};
               bitc  = bitc + 1'b1;
               phase = (bitc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_SEND_LOW;
            end
            PH_ACK_LOW: begin
               scl     = 0;
               sda_low = 0;
               phase   = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
               scl     = 1;
               sda_low = 0;
               if (sda) begin
                  pstat = in_addr ? STATUS_ADDR_NACK : STATUS_DATA_NACK;
                  phase = PH_STOP_A;
               end else begin
                  if (in_addr) begin
                     in_addr = 0;
                     left    = is_read ? r_cnt : w_cnt;
                  end
                  if (left == 0) begin
                     pstat = STATUS_OK;
                     phase = PH_STOP_A;
                  end else begin
                     left = left - 1'b1;
                     if (is_read) start_recv();
                     else start_byte(wbuf[left[POS_W-1:0]]);
                  end
               end
            end
            PH_RECV_LOW: begin
               scl     = 0;
               sda_low = 0;
               phase   = PH_RECV_HIGH;
            end
            PH_RECV_HIGH: begin
               scl   = 1;
               shreg = {shreg[6:0], sda};
               bitc  = bitc + 1'b1;
               if (bitc >= BITS_PER_BYTE) begin
                  r.read_valid = 1;
                  r.read_data  = shreg;
                  r.read_slot  = left[POS_W-1:0];
                  phase        = PH_MACK_LOW;
               end else begin
                  phase = PH_RECV_LOW;
               end
            end
            PH_MACK_LOW: begin
               // ack every byte but the last
               scl     = 0;
               sda_low = (left != 0);
               phase   = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
               scl = 1;
               if (left == 0) begin
                  pstat = STATUS_OK;
                  phase = PH_STOP_A;
               end else begin
                  left = left - 1'b1;
                  start_recv();
               end
            end
            PH_STOP_A: begin
               scl     = 0;
               sda_low = 1;
               phase   = PH_STOP_B;
            end
            PH_STOP_B: begin
               scl     = 1;
               sda_low = 1;
               phase   = PH_STOP_C;
            end
            default: begin
               scl          = 1;
               sda_low      = 0;
               r.job_done   = 1;
               r.job_status = pstat;
               if (is_read) r_pend = 0;
               else w_pend = 0;
               phase = PH_IDLE;
            end
         endcase
      endfunction

      // accepted request word: advance the model and queue the word it must produce
      function void take_item(req_word_type w);
         rsp_word_type r;
         r = '0;
         case (w.kind)
            KIND_TICK: bus_tick(w.sda_sample, r);
            KIND_LOAD: begin
               wbuf[w.position]   = w.data_byte;
               r.request_accepted = 1;
            end
            KIND_WRITE_JOB: begin
               if (!w_pend) begin
                  w_pend             = 1;
                  w_cnt              = clamp_len(w.job_length);
                  r.request_accepted = 1;
               end
            end
            default: begin
               if (!r_pend) begin
                  r_pend             = 1;
                  r_cnt              = clamp_len(w.job_length);
                  r.request_accepted = 1;
               end
            end
         endcase
         r.scl_level    = scl;
         r.sda_pull_low = sda_low;
         r.busy_res     = busy();
         expected_words.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 100) $display("mismatch: %s", msg);
      endtask

      task cmp(string field, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report($sformatf("word %0d %s got %0h expected %0h", word_no, field, got, want));
      endtask

      task check_word(rsp_word_type got);
         rsp_word_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("result word %0d with nothing expected", word_no));
            word_no++;
            return;
         end
         want = expected_words.pop_front();
         cmp("scl_level", 8'(got.scl_level), 8'(want.scl_level));
         cmp("sda_pull_low", 8'(got.sda_pull_low), 8'(want.sda_pull_low));
         cmp("read_valid", 8'(got.read_valid), 8'(want.read_valid));
         cmp("read_data", got.read_data, want.read_data);
         cmp("read_slot", 8'(got.read_slot), 8'(want.read_slot));
         cmp("request_accepted", 8'(got.request_accepted), 8'(want.request_accepted));
         cmp("busy_res", 8'(got.busy_res), 8'(want.busy_res));
         cmp("job_done", 8'(got.job_done), 8'(want.job_done));
         cmp("job_status", 8'(got.job_status), 8'(want.job_status));
         word_no++;
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_word_type      req_word;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_word_type      rsp_word;
   logic              csr_valid;
   logic              csr_ready;
   logic [ADDR_W-1:0] csr_wdata;

   job_scoreboard sb;
   int            items_sent;
   int            burst_left;
   int            stall_mode;
   int            stall_left;

   i2c_master_job_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // receiver stall pattern: free, sparse, periodic and heavy stretches
   initial begin
      stall_mode = 0;
      stall_left = 0;
   end
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(3);
         stall_left = $urandom_range(200, 20);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(3) == 0);
         2:       rsp_stall <= (stall_left % 8 == 0);
         default: rsp_stall <= ($urandom_range(9) < 7);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_word);
   end

   // watchdog: cycles in a row with no word moving on any channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   function req_word_type make_word(logic [1:0] k, logic [7:0] d, logic [POS_W-1:0] p,
                                    logic [LEN_W-1:0] n, logic s);
      req_word_type w;
      w.kind       = k;
      w.data_byte  = d;
      w.position   = p;
      w.job_length = n;
      w.sda_sample = s;
      return w;
   endfunction

   function req_word_type tick_word(logic s);
      return make_word(KIND_TICK, 8'($urandom), 4'($urandom), 5'($urandom), s);
   endfunction

   function req_word_type load_word(logic [POS_W-1:0] p, logic [7:0] d);
      return make_word(KIND_LOAD, d, p, 5'($urandom), 1'($urandom));
   endfunction

   function req_word_type job_word(logic [1:0] k, logic [LEN_W-1:0] n);
      return make_word(k, 8'($urandom), 4'($urandom), n, 1'($urandom));
   endfunction

   function req_word_type noise_word(int lo_kind);
      return make_word(2'($urandom_range(3, lo_kind)), 8'($urandom), 4'($urandom),
                       5'($urandom), 1'($urandom));
   endfunction

   // mostly short jobs, a few at or past the buffer depth
   function logic [LEN_W-1:0] pick_len();
      int p;
      p = $urandom_range(99);
      if (p < 70) return LEN_W'($urandom_range(3));
      if (p < 95) return LEN_W'($urandom_range(15, 4));
      return LEN_W'($urandom_range(31, 16));
   endfunction

   // sda level for the next tick; only the ack sample is steered
   function logic pick_sda(int addr_nack, int data_nack);
      if (sb.phase == PH_ACK_HIGH)
         return $urandom_range(99) < (sb.in_addr ? addr_nack : data_nack);
      return 1'($urandom);
   endfunction

   task send_item(req_word_type w);
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.take_item(w);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(7)) @(negedge clock);
         burst_left = ($urandom_range(99) < 20) ? $urandom_range(200, 50) :
                                                   $urandom_range(12, 1);
      end
   endtask

   // tick until every job is done, with stray loads and requests mixed in
   task run_bus(int addr_nack, int data_nack);
      while (sb.busy()) begin
         if ($urandom_range(99) < 4) send_item(noise_word(1));
         else send_item(tick_word(pick_sda(addr_nack, data_nack)));
      end
   endtask

   task settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_target(logic [ADDR_W-1:0] a);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= a;
      do @(posedge clock); while (!csr_ready);
      sb.set_target(a);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task random_sequence();
      int r;
      int n;
      r = $urandom_range(99);
      if (r < 40) begin
         n = $urandom_range(3);
         repeat (n) send_item(load_word(4'($urandom), 8'($urandom)));
         send_item(job_word(KIND_WRITE_JOB, pick_len()));
         run_bus(3, 5);
      end else if (r < 75) begin
         send_item(job_word(KIND_READ_JOB, pick_len()));
         run_bus(3, 0);
      end else if (r < 88) begin
         if ($urandom_range(1)) begin
            send_item(job_word(KIND_READ_JOB, pick_len()));
            send_item(job_word(KIND_WRITE_JOB, pick_len()));
         end else begin
            send_item(job_word(KIND_WRITE_JOB, pick_len()));
            send_item(job_word(KIND_READ_JOB, pick_len()));
         end
         if ($urandom_range(1)) send_item(job_word(KIND_READ_JOB, pick_len()));
         run_bus(3, 5);
      end else begin
         n = $urandom_range(10, 3);
         repeat (n) send_item(noise_word(0));
         run_bus(20, 20);
      end
   endtask

   initial begin : main
      int        phase_end;
      int        share;
      logic [7:0] d;
      sb         = new();
      items_sent = 0;
      burst_left = 1;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      rsp_stall  = 1'b0;
      csr_valid  = 1'b0;
      csr_wdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_target('0);
      // fill every slot so no write job ever sends an unloaded byte
      for (int i = 0; i < BUFFER_DEPTH_DEF; i++) begin
         d = (i == 0) ? 8'h00 : (i == BUFFER_DEPTH_DEF - 1) ? 8'hFF : 8'($urandom);
         send_item(load_word(POS_W'(i), d));
      end
      send_item(job_word(KIND_WRITE_JOB, 5'd0));
      // refused: a write job is already pending
      send_item(job_word(KIND_WRITE_JOB, 5'd5));
      // longest length, clamped to the buffer depth
      send_item(job_word(KIND_READ_JOB, 5'd31));
      run_bus(0, 0);
      send_item(job_word(KIND_WRITE_JOB, 5'd2));
      run_bus(100, 0);
      send_item(job_word(KIND_WRITE_JOB, 5'd3));
      run_bus(0, 100);
      send_item(job_word(KIND_READ_JOB, 5'd1));
      run_bus(100, 0);
      settle();

      // random phases share what is left of the word budget
      share = (ITEM_TARGET > items_sent) ? (ITEM_TARGET - items_sent) / PHASES : 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0) write_target(7'h7F);
         else if (ph == 2) write_target(7'h00);
         else write_target(7'($urandom));
         phase_end = items_sent + share;
         while (items_sent < phase_end) random_sequence();
         settle();
      end

      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
